// ===== rtl/core/jhd_pkg.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman block decoder package
// Shared constants, codes and a helper function for the entropy decoder.
// ----------------------------------------------------------------------------
package jhd_pkg;

   localparam int MAX_CODE_LEN      = 16;
   localparam int SYMBOLS_PER_TABLE = 256;
   localparam int MAX_FACTOR        = 4;

   localparam int CNT_DEPTH = 4 * MAX_CODE_LEN;
   localparam int SYM_DEPTH = 4 * SYMBOLS_PER_TABLE;
   localparam int CNT_AW    = $clog2(CNT_DEPTH);
   localparam int SYM_AW    = $clog2(SYM_DEPTH);
   localparam int LEN_W     = $clog2(MAX_CODE_LEN);
   localparam int POS_W     = $clog2(SYMBOLS_PER_TABLE);

   localparam logic [7:0] SYM_ZRL   = 8'hF0;
   localparam logic [7:0] BYTE_MARK = 8'hFF;
   localparam logic [7:0] NIBBLE    = 8'h0F;

   localparam int NUM_CFG = 6;

   typedef enum logic [1:0] {
      ACT_SCAN    = 2'd0,
      ACT_COUNT   = 2'd1,
      ACT_SYMBOL  = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_DC_CODE = 2'd0,
      PH_DC_MAG  = 2'd1,
      PH_AC_CODE = 2'd2,
      PH_AC_MAG  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_CODE  = 2'd1,
      ERR_OVERFLOW = 2'd2,
      ERR_MARKER   = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_CNT,
      ST_SYM,
      ST_MARK
   } state_type;

   localparam int CFG_LUMA_H = 0;
   localparam int CFG_LUMA_V = 1;
   localparam int CFG_CB_H   = 2;
   localparam int CFG_CB_V   = 3;
   localparam int CFG_CR_H   = 4;
   localparam int CFG_CR_V   = 5;

   // clamp a sampling factor into 1..MAX_FACTOR
   function automatic logic [2:0] clamp_factor(input logic [2:0] v);
      logic [2:0] r;
      r = v;
      if (r < 3'd1) r = 3'd1;
      if (r > 3'(MAX_FACTOR)) r = 3'(MAX_FACTOR);
      return r;
   endfunction

endpackage

// ===== rtl/core/jhd_if.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman block decoder channels
// Request channel (load, scan and restart words) and response channel (coefficients).
// ----------------------------------------------------------------------------
interface jhd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       table_class;
   logic       table_slot;
   logic [7:0] table_index;
   logic [7:0] value;

   modport source (output valid, action, table_class, table_slot, table_index, value,
                   input ready);
   modport sink   (input valid, action, table_class, table_slot, table_index, value,
                   output ready);
endinterface

interface jhd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         component;
   logic [1:0]         block_row;
   logic [1:0]         block_col;
   logic [5:0]         coef_index;
   logic signed [15:0] coef_value;
   logic               end_of_block;
   logic               end_of_mcu;
   logic [1:0]         error;

   modport source (output valid, component, block_row, block_col, coef_index,
                   coef_value, end_of_block, end_of_mcu, error,
                   input ready);
   modport sink   (input valid, component, block_row, block_col, coef_index,
                   coef_value, end_of_block, end_of_mcu, error,
                   output ready);
endinterface

// ===== rtl/core/jhd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle on a shared address; read data registered, held without read.
// ----------------------------------------------------------------------------
module jhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/core/jpeg_huffman_block_decoder.sv =====
// ----------------------------------------------------------------------------
// JPEG baseline Huffman block decoder
// Entropy stage: canonical Huffman tables in RAM, serial bit decode, MCU walk.
// ----------------------------------------------------------------------------
// A scan word is decoded one bit at a time, MSB first; a code bit needs a
// length count RAM read, then a compare, plus a symbol RAM read when the code
// completes. Words are taken only while idle, so a scan word is fully decoded
// before the next is taken; load and restart words and a dropped stuffed byte
// leave the decoder idle. Results go out through a one-word output register;
// a magnitude bit, a code compare, a symbol step or a marker flag waits while
// that register is full and not being read, so receiver stalls hold the
// decode. Each decoded bit yields at most one result. Tables live in a
// 64-entry count RAM with per-entry valid bits (reset reads as zero) and a
// 1024-entry symbol RAM that must be loaded before use. The user must write
// sampling factors on the csr port only while idle; the block does not check.
// ----------------------------------------------------------------------------
module jpeg_huffman_block_decoder
   import jhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   jhd_req_if.sink    req,
   jhd_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [2:0] csr_write_data
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [2:0]  cfg_ff [NUM_CFG];
   logic [15:0] pred_ff [3];
   logic [15:0] pred_in [3];

   logic [15:0] acc_ff, acc_in;
   logic [4:0]  clen_ff, clen_in;
   logic [16:0] first_ff, first_in;
   logic [8:0]  offset_ff, offset_in;
   logic [15:0] macc_ff, macc_in;
   logic [3:0]  bleft_ff, bleft_in;
   logic [3:0]  run_ff, run_in;
   logic [3:0]  msize_ff, msize_in;
   logic [6:0]  ncoef_ff, ncoef_in;
   logic [1:0]  comp_ff, comp_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic        after_ff_ff, after_ff_in;
   logic [7:0]  shreg_ff, shreg_in;
   logic [2:0]  bitcnt_ff, bitcnt_in;
   logic        cval_ff, cval_in;
   logic [CNT_DEPTH-1:0] cnt_valid_ff;

   // output register
   logic        ovalid_ff;
   logic [1:0]  ocomp_ff, orow_ff, ocol_ff, oerr_ff;
   logic [5:0]  oidx_ff;
   logic [15:0] oval_ff;
   logic        oeob_ff, oeom_ff;

   // step control
   logic        emit, e_eob, do_adv, bit_done, go_cnt, go_sym, go_mark, go_bit;
   logic [5:0]  e_idx;
   logic [15:0] e_val;
   error_type   e_err;

   // RAM ports
   logic              cnt_we, cnt_re, sym_we, sym_re;
   logic [CNT_AW-1:0] cnt_addr;
   logic [SYM_AW-1:0] sym_addr;
   logic [7:0]        cnt_rdata, sym_rdata;

   logic        out_free, accept, bit_val, last_blk, in_dc;
   logic [1:0]  tsel;
   logic [1:0]  cclamp;
   logic [7:0]  cnt;
   logic [15:0] acc_new, macc_new, ext_val, half_val, full_val, dc_sum;
   logic [17:0] diff;
   logic [9:0]  pos, off_sum;
   logic [17:0] first_sum;
   logic [4:0]  clen_new;
   logic [3:0]  bl_new, ms;
   logic [6:0]  nc_run;
   logic [2:0]  col_inc, row_inc;

   assign out_free = !ovalid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign bit_val = shreg_ff[7];
   assign cclamp = (comp_ff > 2'd2) ? 2'd2 : comp_ff;
   assign tsel = {phase_ff == PH_AC_CODE, comp_ff != 2'd0};
   assign in_dc = (phase_ff == PH_DC_CODE) || (phase_ff == PH_DC_MAG);
   assign last_blk = (comp_ff >= 2'd2)
                  && ({1'b0, row_ff} + 3'd1 >= clamp_factor(cfg_ff[CFG_CR_V]))
                  && ({1'b0, col_ff} + 3'd1 >= clamp_factor(cfg_ff[CFG_CR_H]));

   // code search arithmetic; diff[17] marks an accumulator below first code
   assign cnt       = cval_ff ? cnt_rdata : 8'd0;
   assign acc_new   = {acc_ff[14:0], bit_val};
   assign diff      = {2'b0, acc_new} - {1'b0, first_ff};
   assign pos       = {1'b0, offset_ff} + {2'b0, diff[7:0]};
   assign off_sum   = {1'b0, offset_ff} + {2'b0, cnt};
   assign first_sum = {1'b0, first_ff} + {10'b0, cnt};
   assign clen_new  = clen_ff + 5'd1;

   // magnitude arithmetic
   assign macc_new = {macc_ff[14:0], bit_val};
   assign bl_new   = (bleft_ff > 4'd0) ? bleft_ff - 4'd1 : 4'd0;
   assign ms       = (msize_ff < 4'd1) ? 4'd1 : msize_ff;
   assign half_val = 16'(1) << (ms - 4'd1);
   assign full_val = (16'(1) << ms) - 16'd1;
   assign ext_val  = (macc_new < half_val) ? macc_new - full_val : macc_new;
   assign nc_run   = ncoef_ff + {3'b0, run_ff};

   // RAM addressing: loads in idle, reads while decoding
   always_comb begin
      cnt_we = accept && (action_type'(req.action) == ACT_COUNT)
            && (req.table_index < 8'(MAX_CODE_LEN));
      sym_we = accept && (action_type'(req.action) == ACT_SYMBOL)
            && ({1'b0, req.table_index} < 9'(SYMBOLS_PER_TABLE));
      cnt_re = (state_ff == ST_BIT) && ((phase_ff == PH_DC_CODE) || (phase_ff == PH_AC_CODE));
      sym_re = go_sym;
      if (cnt_we) begin
         cnt_addr = {req.table_class, req.table_slot, req.table_index[LEN_W-1:0]};
      end else begin
         cnt_addr = {tsel, clen_ff[LEN_W-1:0]};
      end
      if (sym_we) begin
         sym_addr = {req.table_class, req.table_slot, req.table_index[POS_W-1:0]};
      end else begin
         sym_addr = {tsel, pos[POS_W-1:0]};
      end
   end

   jhd_ram #(.WIDTH(8), .DEPTH(CNT_DEPTH)) u_cnt_ram (
      .clock(clock), .write_enable(cnt_we), .read_enable(cnt_re),
      .addr(cnt_addr), .write_data(req.value), .read_data(cnt_rdata));

   jhd_ram #(.WIDTH(8), .DEPTH(SYM_DEPTH)) u_sym_ram (
      .clock(clock), .write_enable(sym_we), .read_enable(sym_re),
      .addr(sym_addr), .write_data(req.value), .read_data(sym_rdata));

   // decode datapath
   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff; clen_in = clen_ff; first_in = first_ff; offset_in = offset_ff;
      macc_in = macc_ff; bleft_in = bleft_ff; run_in = run_ff; msize_in = msize_ff;
      ncoef_in = ncoef_ff; comp_in = comp_ff; row_in = row_ff; col_in = col_ff;
      after_ff_in = after_ff_ff; shreg_in = shreg_ff; bitcnt_in = bitcnt_ff;
      cval_in = cval_ff;
      for (int i = 0; i < 3; i++) pred_in[i] = pred_ff[i];
      emit = 1'b0; e_idx = 6'd0; e_val = 16'd0; e_eob = 1'b0; e_err = ERR_NONE;
      do_adv = 1'b0; bit_done = 1'b0; go_cnt = 1'b0; go_sym = 1'b0;
      go_mark = 1'b0; go_bit = 1'b0;
      dc_sum = pred_ff[cclamp] + ext_val;
      col_inc = 3'd0; row_inc = 3'd0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action_type'(req.action))
                  ACT_RESTART: begin
                     for (int i = 0; i < 3; i++) pred_in[i] = 16'd0;
                     acc_in = 16'd0; clen_in = 5'd0; first_in = 17'd0; offset_in = 9'd0;
                     phase_in = PH_DC_CODE;
                     macc_in = 16'd0; bleft_in = 4'd0; run_in = 4'd0; msize_in = 4'd0;
                     ncoef_in = 7'd0; comp_in = 2'd0; row_in = 2'd0; col_in = 2'd0;
                     after_ff_in = 1'b0;
                  end
                  ACT_SCAN: begin
                     if (after_ff_ff) begin
                        after_ff_in = 1'b0;
                        go_mark = (req.value != 8'd0);
                     end else begin
                        shreg_in = req.value;
                        bitcnt_in = 3'd7;
                        after_ff_in = (req.value == BYTE_MARK);
                        go_bit = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MARK: begin
            if (out_free) begin
               emit = 1'b1; e_err = ERR_MARKER;
            end
         end
         ST_BIT: begin
            if (cnt_re) begin
               cval_in = cnt_valid_ff[cnt_addr];
               go_cnt = 1'b1;
            end else if (out_free) begin
               // magnitude bit
               bit_done = 1'b1;
               macc_in = macc_new;
               bleft_in = bl_new;
               if (bl_new == 4'd0) begin
                  if (phase_ff == PH_DC_MAG) begin
                     pred_in[cclamp] = dc_sum;
                     emit = 1'b1; e_val = dc_sum;
                     phase_in = PH_AC_CODE; ncoef_in = 7'd1;
                  end else if (nc_run >= 7'd63) begin
                     emit = 1'b1; e_idx = 6'd63; e_val = ext_val; e_eob = 1'b1;
                     do_adv = 1'b1;
                  end else begin
                     emit = 1'b1; e_idx = nc_run[5:0]; e_val = ext_val;
                     ncoef_in = nc_run + 7'd1;
                     phase_in = PH_AC_CODE;
                  end
               end
            end
         end
         ST_CNT: begin
            if (out_free) begin
               acc_in = acc_new;
               clen_in = clen_new;
               if (!diff[17] && (diff[16:0] < {9'b0, cnt})) begin
                  if (pos >= 10'(SYMBOLS_PER_TABLE)) begin
                     emit = 1'b1; e_err = ERR_NO_CODE;
                     bit_done = 1'b1; do_adv = 1'b1;
                  end else begin
                     go_sym = 1'b1;
                  end
               end else begin
                  offset_in = (off_sum > 10'(SYMBOLS_PER_TABLE)) ?
                              9'(SYMBOLS_PER_TABLE) : off_sum[8:0];
                  first_in = {first_sum[15:0], 1'b0};
                  bit_done = 1'b1;
                  if (clen_new >= 5'(MAX_CODE_LEN)) begin
                     emit = 1'b1; e_err = ERR_NO_CODE; do_adv = 1'b1;
                  end
               end
               if (emit) begin
                  e_eob = 1'b1;
                  e_idx = in_dc ? 6'd0 : ncoef_ff[5:0];
               end
            end
         end
         ST_SYM: begin
            if (out_free) begin
               bit_done = 1'b1;
               acc_in = 16'd0; clen_in = 5'd0; first_in = 17'd0; offset_in = 9'd0;
               if (phase_ff == PH_DC_CODE) begin
                  if (sym_rdata > NIBBLE) begin
                     emit = 1'b1; e_eob = 1'b1; e_err = ERR_NO_CODE; do_adv = 1'b1;
                  end else if (sym_rdata == 8'd0) begin
                     emit = 1'b1; e_val = pred_ff[cclamp];
                     phase_in = PH_AC_CODE; ncoef_in = 7'd1;
                  end else begin
                     msize_in = sym_rdata[3:0]; bleft_in = sym_rdata[3:0];
                     macc_in = 16'd0; phase_in = PH_DC_MAG;
                  end
               end else begin
                  e_idx = ncoef_ff[5:0];
                  if (sym_rdata == 8'd0) begin
                     emit = 1'b1; e_idx = 6'd63; e_eob = 1'b1; do_adv = 1'b1;
                  end else if (sym_rdata == SYM_ZRL) begin
                     if (ncoef_ff + 7'd16 > 7'd64) begin
                        emit = 1'b1; e_eob = 1'b1; e_err = ERR_OVERFLOW; do_adv = 1'b1;
                     end else begin
                        ncoef_in = ncoef_ff + 7'd16;
                        if (ncoef_ff + 7'd16 >= 7'd64) begin
                           emit = 1'b1; e_idx = 6'd63; e_eob = 1'b1; do_adv = 1'b1;
                        end
                     end
                  end else if ((sym_rdata & NIBBLE) == 8'd0) begin
                     emit = 1'b1; e_eob = 1'b1; e_err = ERR_NO_CODE; do_adv = 1'b1;
                  end else if (ncoef_ff + {3'b0, sym_rdata[7:4]} > 7'd63) begin
                     emit = 1'b1; e_eob = 1'b1; e_err = ERR_OVERFLOW; do_adv = 1'b1;
                  end else begin
                     run_in = sym_rdata[7:4];
                     msize_in = sym_rdata[3:0]; bleft_in = sym_rdata[3:0];
                     macc_in = 16'd0; phase_in = PH_AC_MAG;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // next block in MCU order
      if (do_adv) begin
         acc_in = 16'd0; clen_in = 5'd0; first_in = 17'd0; offset_in = 9'd0;
         phase_in = PH_DC_CODE;
         ncoef_in = 7'd0;
         col_inc = {1'b0, col_ff} + 3'd1;
         col_in = col_inc[1:0];
         if (col_inc >= clamp_factor(cfg_ff[{cclamp, 1'b0}])) begin
            col_in = 2'd0;
            row_inc = {1'b0, row_ff} + 3'd1;
            row_in = row_inc[1:0];
            if (row_inc >= clamp_factor(cfg_ff[{cclamp, 1'b1}])) begin
               row_in = 2'd0;
               comp_in = (cclamp >= 2'd2) ? 2'd0 : cclamp + 2'd1;
            end
         end
      end

      if (bit_done) begin
         shreg_in = {shreg_ff[6:0], 1'b0};
         bitcnt_in = bitcnt_ff - 3'd1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go_bit) state_in = ST_BIT;
            else if (go_mark) state_in = ST_MARK;
         end
         ST_MARK: begin
            if (emit) state_in = ST_IDLE;
         end
         ST_BIT, ST_CNT, ST_SYM: begin
            if (go_cnt) state_in = ST_CNT;
            else if (go_sym) state_in = ST_SYM;
            else if (bit_done) state_in = (bitcnt_ff == 3'd0) ? ST_IDLE : ST_BIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DC_CODE;
         acc_ff <= 16'd0; clen_ff <= 5'd0; first_ff <= 17'd0; offset_ff <= 9'd0;
         macc_ff <= 16'd0; bleft_ff <= 4'd0; run_ff <= 4'd0; msize_ff <= 4'd0;
         ncoef_ff <= 7'd0; comp_ff <= 2'd0; row_ff <= 2'd0; col_ff <= 2'd0;
         after_ff_ff <= 1'b0; bitcnt_ff <= 3'd0;
         for (int i = 0; i < 3; i++) pred_ff[i] <= 16'd0;
         cnt_valid_ff <= '0;
         cfg_ff[CFG_LUMA_H] <= 3'd2; cfg_ff[CFG_LUMA_V] <= 3'd2;
         cfg_ff[CFG_CB_H] <= 3'd1; cfg_ff[CFG_CB_V] <= 3'd1;
         cfg_ff[CFG_CR_H] <= 3'd1; cfg_ff[CFG_CR_V] <= 3'd1;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         acc_ff <= acc_in; clen_ff <= clen_in; first_ff <= first_in; offset_ff <= offset_in;
         macc_ff <= macc_in; bleft_ff <= bleft_in; run_ff <= run_in; msize_ff <= msize_in;
         ncoef_ff <= ncoef_in; comp_ff <= comp_in; row_ff <= row_in; col_ff <= col_in;
         after_ff_ff <= after_ff_in; bitcnt_ff <= bitcnt_in;
         for (int i = 0; i < 3; i++) pred_ff[i] <= pred_in[i];
         if (cnt_we) cnt_valid_ff[cnt_addr] <= 1'b1;
         if (csr_write_enable && (csr_index < 3'(NUM_CFG))) begin
            cfg_ff[csr_index] <= csr_write_data;
         end
         if (emit) ovalid_ff <= 1'b1;
         else if (rsp.ready) ovalid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      cval_ff <= cval_in;
      if (emit) begin
         ocomp_ff <= comp_ff; orow_ff <= row_ff; ocol_ff <= col_ff;
         oidx_ff <= e_idx; oval_ff <= e_val; oeob_ff <= e_eob;
         oeom_ff <= e_eob && last_blk; oerr_ff <= e_err;
      end
   end

   assign rsp.valid        = ovalid_ff;
   assign rsp.component    = ocomp_ff;
   assign rsp.block_row    = orow_ff;
   assign rsp.block_col    = ocol_ff;
   assign rsp.coef_index   = oidx_ff;
   assign rsp.coef_value   = oval_ff;
   assign rsp.end_of_block = oeob_ff;
   assign rsp.end_of_mcu   = oeom_ff;
   assign rsp.error        = oerr_ff;

endmodule

// ===== rtl/core/jhd_checker.sv =====
// ----------------------------------------------------------------------------
// JPEG Huffman block decoder checker
// Port-level properties of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module jhd_checker
   import jhd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_coef_index,
   input logic [15:0] rsp_coef_value,
   input logic        rsp_end_of_block,
   input logic        rsp_end_of_mcu,
   input logic [1:0]  rsp_error
);

   // a stalled word stays valid with its value held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coef_value))
      else $error("response word changed while stalled");

   // nothing pending right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // MCU end only on a block end
   a_mcu: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_mcu |-> rsp_end_of_block)
      else $error("end of MCU without end of block");

   // stuffed-marker word is a lone flag
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_MARKER |->
         rsp_coef_index == 6'd0 && rsp_coef_value == 16'd0 && !rsp_end_of_block)
      else $error("bad marker word");

   // decode errors close the block with a zero value
   a_decode_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error == ERR_NO_CODE || rsp_error == ERR_OVERFLOW) |->
         rsp_end_of_block && rsp_coef_value == 16'd0)
      else $error("decode error word does not close block");

endmodule

bind jpeg_huffman_block_decoder jhd_checker u_jhd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_coef_index(rsp.coef_index),
   .rsp_coef_value(rsp.coef_value),
   .rsp_end_of_block(rsp.end_of_block),
   .rsp_end_of_mcu(rsp.end_of_mcu),
   .rsp_error(rsp.error)
);

// ===== dv/jhd_coef_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient checker for the JPEG Huffman block decoder
// Watches the request, response and csr ports, keeps its own copy of the
// tables, predictors and bit decoder, and compares each response word with
// the oldest predicted coefficient word.
// ----------------------------------------------------------------------------
module jhd_coef_checker
   import jhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   jhd_req_if         req,
   jhd_rsp_if         rsp,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [2:0] csr_write_data,
   output int         fail_count,
   output int         words_pending
);

   localparam int CODE_WAIT = -1;
   localparam int CODE_BAD  = -2;

   typedef struct packed {
      logic [1:0]  component;
      logic [1:0]  block_row;
      logic [1:0]  block_col;
      logic [5:0]  coef_index;
      logic [15:0] coef_value;
      logic        end_of_block;
      logic        end_of_mcu;
      logic [1:0]  error;
   } coef_word_type;

   coef_word_type expected_coefs[$];

   logic [7:0]  sym_mem [SYM_DEPTH];
   logic [7:0]  cnt_mem [CNT_DEPTH];
   logic [15:0] dc_pred [3];
   logic [2:0]  factors [NUM_CFG];
   phase_type   phase;
   int unsigned code_acc, code_len, first_code, sym_offset;
   int unsigned mag_acc, bits_left, pend_run, mag_size, next_coef;
   int unsigned comp, row, col;
   bit          after_mark;
   int          mismatches;

   function automatic int unsigned eff_factor(int unsigned i);
      int unsigned v;
      v = factors[i % NUM_CFG];
      if (v < 1) v = 1;
      if (v > MAX_FACTOR) v = MAX_FACTOR;
      return v;
   endfunction

   function automatic bit in_last_block();
      return comp >= 2 && row + 1 >= eff_factor(CFG_CR_V) && col + 1 >= eff_factor(CFG_CR_H);
   endfunction

   function automatic void clear_search();
      code_acc = 0;
      code_len = 0;
      first_code = 0;
      sym_offset = 0;
   endfunction

   // step to the next block in MCU order
   function automatic void next_block();
      int unsigned c;
      c = (comp > 2) ? 2 : comp;
      clear_search();
      phase = PH_DC_CODE;
      next_coef = 0;
      col++;
      if (col >= eff_factor(c * 2)) begin
         col = 0;
         row++;
         if (row >= eff_factor(c * 2 + 1)) begin
            row = 0;
            comp = (c >= 2) ? 0 : c + 1;
         end
      end
   endfunction

   function automatic void push_coef(int unsigned idx, int unsigned val, bit eob,
                                     error_type err);
      coef_word_type w;
      w.component    = 2'(comp);
      w.block_row    = 2'(row);
      w.block_col    = 2'(col);
      w.coef_index   = 6'(idx);
      w.coef_value   = 16'(val);
      w.end_of_block = eob;
      w.end_of_mcu   = eob && in_last_block();
      w.error        = err;
      expected_coefs.insert(expected_coefs.size(), w);
   endfunction

   function automatic void close_block(int unsigned idx, int unsigned val, error_type err);
      push_coef(idx, val, 1'b1, err);
      next_block();
   endfunction

   function automatic void abort_block(error_type err);
      int unsigned idx;
      idx = (phase == PH_DC_CODE || phase == PH_DC_MAG) ? 0 : (next_coef & 63);
      close_block(idx, 0, err);
   endfunction

   // one bit of canonical code search; symbol, CODE_WAIT or CODE_BAD
   function automatic int code_bit(int unsigned cls, int unsigned b);
      int unsigned t, cnt, pos;
      t = cls * 2 + ((comp != 0) ? 1 : 0);
      code_acc = ((code_acc << 1) | b) & 16'hFFFF;
      code_len++;
      cnt = cnt_mem[t * MAX_CODE_LEN + ((code_len - 1) % MAX_CODE_LEN)];
      if (code_acc >= first_code && code_acc - first_code < cnt) begin
         pos = sym_offset + (code_acc - first_code);
         if (pos >= SYMBOLS_PER_TABLE) return CODE_BAD;
         return int'(sym_mem[t * SYMBOLS_PER_TABLE + pos]);
      end
      sym_offset += cnt;
      if (sym_offset > SYMBOLS_PER_TABLE) sym_offset = SYMBOLS_PER_TABLE;
      first_code = ((first_code + cnt) << 1) & 17'h1FFFF;
      if (code_len >= MAX_CODE_LEN) return CODE_BAD;
      return CODE_WAIT;
   endfunction

   function automatic int unsigned sign_extend(int unsigned v, int unsigned s);
      if (v < (1 << (s - 1))) v = v - ((1 << s) - 1);
      return v & 16'hFFFF;
   endfunction

   function automatic void dc_done(int unsigned diff);
      int unsigned c;
      c = (comp > 2) ? 2 : comp;
      dc_pred[c] = dc_pred[c] + 16'(diff);
      push_coef(0, dc_pred[c], 1'b0, ERR_NONE);
      phase = PH_AC_CODE;
      next_coef = 1;
   endfunction

   function automatic void decode_bit(int unsigned b);
      int          r;
      int unsigned s, run, size;
      if (phase == PH_DC_CODE || phase == PH_AC_CODE) begin
         r = code_bit((phase == PH_AC_CODE) ? 1 : 0, b);
         if (r == CODE_WAIT) return;
         if (r == CODE_BAD) begin
            abort_block(ERR_NO_CODE);
            return;
         end
         clear_search();
         s = r;
         if (phase == PH_DC_CODE) begin
            if (s > NIBBLE) begin
               abort_block(ERR_NO_CODE);
               return;
            end
            if (s == 0) begin
               dc_done(0);
               return;
            end
            mag_size = s;
            bits_left = s;
            mag_acc = 0;
            phase = PH_DC_MAG;
            return;
         end
         // AC symbol: EOB, ZRL or run/size
         if (s == 0) begin
            close_block(63, 0, ERR_NONE);
            return;
         end
         if (s == SYM_ZRL) begin
            if (next_coef + 16 > 64) begin
               abort_block(ERR_OVERFLOW);
               return;
            end
            next_coef += 16;
            if (next_coef >= 64) close_block(63, 0, ERR_NONE);
            return;
         end
         run = s >> 4;
         size = s & NIBBLE;
         if (size == 0) begin
            abort_block(ERR_NO_CODE);
            return;
         end
         if (next_coef + run > 63) begin
            abort_block(ERR_OVERFLOW);
            return;
         end
         pend_run = run;
         mag_size = size;
         bits_left = size;
         mag_acc = 0;
         phase = PH_AC_MAG;
         return;
      end
      // magnitude bits
      mag_acc = ((mag_acc << 1) | b) & 16'hFFFF;
      if (bits_left > 0) bits_left--;
      if (bits_left != 0) return;
      if (mag_size < 1 || mag_size > 15) mag_size = 1;
      size = sign_extend(mag_acc, mag_size);
      if (phase == PH_DC_MAG) begin
         dc_done(size);
         return;
      end
      next_coef += pend_run;
      if (next_coef >= 63) begin
         close_block(63, size, ERR_NONE);
         return;
      end
      push_coef(next_coef, size, 1'b0, ERR_NONE);
      next_coef++;
      phase = PH_AC_CODE;
   endfunction

   function automatic void rescan();
      for (int i = 0; i < 3; i++) dc_pred[i] = '0;
      clear_search();
      phase = PH_DC_CODE;
      mag_acc = 0;
      bits_left = 0;
      pend_run = 0;
      mag_size = 0;
      next_coef = 0;
      comp = 0;
      row = 0;
      col = 0;
      after_mark = 0;
   endfunction

   function automatic void take_word(logic [1:0] act, logic cls, logic id,
                                     logic [7:0] idx, logic [7:0] val);
      int unsigned t;
      int          i;
      t = cls * 2 + id;
      case (act)
         ACT_COUNT: begin
            if (idx < MAX_CODE_LEN) cnt_mem[t * MAX_CODE_LEN + idx] = val;
         end
         ACT_SYMBOL: begin
            if (idx < SYMBOLS_PER_TABLE) sym_mem[t * SYMBOLS_PER_TABLE + idx] = val;
         end
         ACT_RESTART: begin
            rescan();
         end
         default: begin
            if (after_mark) begin
               // stuffed byte after 0xFF is dropped
               after_mark = 0;
               if (val != 0) push_coef(0, 0, 1'b0, ERR_MARKER);
            end else begin
               for (i = 7; i >= 0; i--) decode_bit(val[i]);
               if (val == BYTE_MARK) after_mark = 1;
            end
         end
      endcase
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < SYM_DEPTH; i++) sym_mem[i] = '0;
      for (int i = 0; i < CNT_DEPTH; i++) cnt_mem[i] = '0;
      factors[CFG_LUMA_H] = 3'd2;
      factors[CFG_LUMA_V] = 3'd2;
      factors[CFG_CB_H]   = 3'd1;
      factors[CFG_CB_V]   = 3'd1;
      factors[CFG_CR_H]   = 3'd1;
      factors[CFG_CR_V]   = 3'd1;
      rescan();
      expected_coefs.delete();
   endfunction

   // compare retired words, then predict from accepted words
   always @(posedge clock) begin
      coef_word_type got, want;
      if (reset) begin
         reset_model();
         mismatches = 0;
         fail_count <= 0;
      end else begin
         if (csr_write_enable && csr_index < NUM_CFG) factors[csr_index] = csr_write_data;
         if (rsp.valid && rsp.ready) begin
            got.component    = rsp.component;
            got.block_row    = rsp.block_row;
            got.block_col    = rsp.block_col;
            got.coef_index   = rsp.coef_index;
            got.coef_value   = rsp.coef_value;
            got.end_of_block = rsp.end_of_block;
            got.end_of_mcu   = rsp.end_of_mcu;
            got.error        = rsp.error;
            if (expected_coefs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected coef word %h", $realtime, got);
            end else begin
               want = expected_coefs.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: coef word mismatch", $realtime);
                     $display("  expected comp %0d row %0d col %0d idx %0d val %0d eob %0b eom %0b err %0d",
                              want.component, want.block_row, want.block_col, want.coef_index,
                              $signed(want.coef_value), want.end_of_block, want.end_of_mcu,
                              want.error);
                     $display("  actual   comp %0d row %0d col %0d idx %0d val %0d eob %0b eom %0b err %0d",
                              got.component, got.block_row, got.block_col, got.coef_index,
                              $signed(got.coef_value), got.end_of_block, got.end_of_mcu,
                              got.error);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            take_word(req.action, req.table_class, req.table_slot, req.table_index, req.value);
         fail_count <= mismatches;
      end
      words_pending <= expected_coefs.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG Huffman block decoder testbench
// Loads random canonical tables, sends directed and random scan, load and
// restart words across several sampling factor settings and idle patterns,
// and leaves all prediction and comparison to the coefficient checker.
// ----------------------------------------------------------------------------
module testbench;
   import jhd_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [2:0] csr_index;
   logic [2:0] csr_write_data;

   jhd_req_if req_ch ();
   jhd_rsp_if rsp_ch ();

   int fail_count;
   int words_pending;
   int idle_pct;
   int stall_pct;
   int hold_left;
   logic [7:0] last_scan;

   jpeg_huffman_block_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   jhd_coef_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .words_pending    (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

   // response side: long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_word(input action_type act, input logic cls, input logic id,
                            input logic [7:0] idx, input logic [7:0] val);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.table_class <= cls;
      req_ch.table_slot  <= id;
      req_ch.table_index <= idx;
      req_ch.value       <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic scan_byte(input logic [7:0] val);
      send_word(ACT_SCAN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), val);
      last_scan = val;
   endtask

   task automatic restart_scan();
      send_word(ACT_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // random canonical table; all-ones codes stay free, every used slot written
   task automatic build_table(input logic cls, input logic id);
      int unsigned code, room, cnt, total, r;
      logic [7:0]  sym;
      code = 0;
      total = 0;
      for (int len = 0; len < MAX_CODE_LEN; len++) begin
         room = (1 << (len + 1)) - code - 1;
         cnt = $urandom_range(0, 3);
         if (len == 1 && cnt == 0) cnt = 1;
         if (cnt > room) cnt = room;
         if (total + cnt > 24) cnt = 24 - total;
         total += cnt;
         code = (code + cnt) << 1;
         send_word(ACT_COUNT, cls, id, 8'(len), 8'(cnt));
      end
      for (int p = 0; p < total; p++) begin
         r = $urandom_range(0, 99);
         if (p == 0) sym = 8'h00;
         else if (cls == 1'b0) begin
            if (r < 85) sym = 8'($urandom_range(0, 11));
            else if (r < 95) sym = 8'($urandom_range(12, 15));
            else sym = 8'($urandom_range(16, 255));
         end else begin
            if (r < 8) sym = SYM_ZRL;
            else if (r < 14) sym = {4'($urandom_range(1, 14)), 4'h0};
            else if (r < 20) sym = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))};
            else sym = {4'($urandom_range(0, 3)), 4'($urandom_range(1, 6))};
         end
         send_word(ACT_SYMBOL, cls, id, 8'(p), sym);
      end
   endtask

   task automatic set_factors(input logic [2:0] lh, input logic [2:0] lv, input logic [2:0] bh,
                              input logic [2:0] bv, input logic [2:0] rh, input logic [2:0] rv);
      logic [2:0] f [NUM_CFG];
      f[CFG_LUMA_H] = lh;
      f[CFG_LUMA_V] = lv;
      f[CFG_CB_H]   = bh;
      f[CFG_CB_V]   = bv;
      f[CFG_CR_H]   = rh;
      f[CFG_CR_V]   = rv;
      for (int i = 0; i < NUM_CFG; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_write_data   <= f[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // drain all predicted words, then let a last scan word finish
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_words(input int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 82) begin
            if (last_scan == BYTE_MARK && $urandom_range(0, 99) < 70) scan_byte(8'h00);
            else if ($urandom_range(0, 99) < 4) scan_byte(BYTE_MARK);
            else scan_byte(8'($urandom_range(0, 255)));
         end else if (r < 87) begin
            restart_scan();
         end else if (r < 91) begin
            // count index beyond the table: ignored
            send_word(ACT_COUNT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(MAX_CODE_LEN, 255)), 8'($urandom_range(0, 255)));
         end else if (r < 96) begin
            send_word(ACT_SYMBOL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            restart_scan();
         end
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_SCAN;
      req_ch.table_class = 1'b0;
      req_ch.table_slot  = 1'b0;
      req_ch.table_index = 8'h00;
      req_ch.value       = 8'h00;
      rsp_ch.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = 3'd0;
      csr_write_data     = 3'd0;
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = 0;
      last_scan = 8'h00;
      reset     = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // symbol position past the table end: 255 codes of length 8, then 2 of 9
      for (int len = 0; len < MAX_CODE_LEN; len++)
         send_word(ACT_COUNT, 1'b0, 1'b0, 8'(len), (len == 7) ? 8'd255 : (len == 8) ? 8'd2 : 8'd0);
      scan_byte(BYTE_MARK);
      scan_byte(8'h00);
      scan_byte(8'h80);
      restart_scan();

      build_table(1'b0, 1'b0);
      build_table(1'b0, 1'b1);
      build_table(1'b1, 1'b0);
      build_table(1'b1, 1'b1);

      // stuffing, marker in data, sixteen ones with no code
      scan_byte(8'h00);
      scan_byte(BYTE_MARK);
      scan_byte(8'h00);
      scan_byte(BYTE_MARK);
      scan_byte(8'h37);
      restart_scan();
      scan_byte(BYTE_MARK);
      scan_byte(8'h00);
      scan_byte(BYTE_MARK);
      scan_byte(8'h00);
      send_word(ACT_COUNT, 1'b1, 1'b1, 8'hFF, 8'hFF);
      send_word(ACT_SYMBOL, 1'b1, 1'b0, 8'hFF, 8'hA5);
      restart_scan();
      scan_byte(8'hAA);
      scan_byte(8'h55);
      scan_byte(8'h0F);
      scan_byte(8'hF0);

      // random phases over factor settings and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            1: set_factors(3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1);
            2: set_factors(3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4);
            3: set_factors(3'd7, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0);
            4: set_factors(3'd3, 3'd2, 3'd1, 3'd4, 3'd2, 3'd3);
            5: set_factors(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            default: ;
         endcase
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         if (ph == 0) hold_left = 300;
         random_words(20);
      end

      wait_idle();
      if (fail_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/jhd_pkg.sv
rtl/core/jhd_if.sv
rtl/core/jhd_ram.sv
rtl/core/jpeg_huffman_block_decoder.sv
rtl/core/jhd_checker.sv
dv/jhd_coef_checker.sv
dv/testbench.sv
